### rtl/gdf_pkg.sv
// Shared types, constants and state encodings for the grouped decimal formatter.
// No dependencies; imported by every module of the block.
package gdf_pkg;

    localparam int VALUE_BITS  = 64;                      // width of the signed input
    localparam int DIGIT_COUNT = 20;                      // decimal digits of 2^64
    localparam int DIGIT_BITS  = 4;
    localparam int BCD_BITS    = DIGIT_COUNT * DIGIT_BITS;
    localparam int CNT_BITS    = $clog2(VALUE_BITS);
    localparam int IDX_BITS    = $clog2(DIGIT_COUNT);
    localparam int CHAR_BITS   = 8;
    localparam int SEP_BITS    = 8;
    localparam int GRP_BITS    = 5;
    localparam int CFG_DATA_BITS = 8;
    localparam int QDEPTH      = 2;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SEP_BITS-1:0]  SEPARATOR_RESET  = 8'd44;
    localparam logic [GRP_BITS-1:0]  GROUP_SIZE_RESET = 5'd3;

    typedef enum logic {
        CFG_SEPARATOR  = 1'b0,
        CFG_GROUP_SIZE = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SKIP,
        B_SIGN,
        B_DIGIT,
        B_SEP
    } back_state_t;

    // One converted number waiting for the emitter.
    typedef struct packed {
        logic [BCD_BITS-1:0]    bcd;       // digit i in bits [4i+3:4i]
        logic                   negative;
        logic [DIGIT_COUNT-1:0] sep_after; // bit i: separator follows digit i
    } gdf_entry_t;

endpackage

### rtl/grouped_decimal_formatter.sv
// Top level of the grouped decimal formatter: configuration registers and
// the front end, queue and emitter. Depends on gdf_pkg, gdf_front, gdf_queue, gdf_back.
//
// Usage:
//   s_* channel takes one request per number: s_tdata is the signed 64-bit value.
//   m_* channel returns its decimal text one ASCII character per transfer, most
//   significant first: '-' for negative values, then the digits, with the
//   separator byte after every group_size digits counted from the right.
//   m_tlast marks the final character; zero gives the single character '0'.
//   cfg_we/cfg_addr/cfg_wdata write separator (index 0) and group_size
//   (index 1); write them only while the block is idle.
// Timing:
//   The front end holds one request from accept through shift-and-add-3
//   conversion (one input bit per cycle) to a push into a two-entry queue,
//   waiting there while the queue is full, and takes no new request until
//   that push. The emitter pops an entry, skips up to 19 leading zero digits
//   one per cycle, then sends up to 38 characters one per cycle unless the
//   receiver stalls.
// Reset (aresetn low, synchronous) restores separator ',' and group_size 3 and
//   empties the queue and the output register. When the receiver stalls, the
//   output register holds its character, the queue fills, and s_tready stays
//   low once the converter has a finished number it cannot push.
module grouped_decimal_formatter (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic                             cfg_addr,
    input  logic [gdf_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    // input requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gdf_pkg::VALUE_BITS-1:0]   s_tdata,   // [63:0] value
    // output characters
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gdf_pkg::CHAR_BITS-1:0]    m_tdata,   // [7:0] character
    output logic                             m_tlast
);
    import gdf_pkg::*;

    logic [SEP_BITS-1:0] separator_reg;
    logic [GRP_BITS-1:0] group_size_reg;

    logic       front_push;
    logic       queue_ready;
    gdf_entry_t front_entry;
    logic       queue_valid;
    logic       back_pop;
    gdf_entry_t queue_entry;

    // configuration registers; writes land immediately
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg  <= SEPARATOR_RESET;
            group_size_reg <= GROUP_SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_SEPARATOR:  separator_reg  <= cfg_wdata[SEP_BITS-1:0];
                CFG_GROUP_SIZE: group_size_reg <= cfg_wdata[GRP_BITS-1:0];
                default:        separator_reg  <= separator_reg;
            endcase
        end
    end

    // front end: accept and convert
    gdf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .group_size (group_size_reg),
        .push       (front_push),
        .push_ready (queue_ready),
        .push_entry (front_entry)
    );

    // decouple conversion from emission
    gdf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_push),
        .push_entry (front_entry),
        .push_ready (queue_ready),
        .pop        (back_pop),
        .pop_valid  (queue_valid),
        .pop_entry  (queue_entry)
    );

    // emitter: characters out
    gdf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (queue_valid),
        .pop_entry (queue_entry),
        .pop       (back_pop),
        .separator (separator_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // the converter is busy right after it takes a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("front end accepted a request while converting");

    // the converter frees up only by handing a number to the queue
    a_ready_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) && $past(aresetn) |-> $past(front_push))
        else $error("front end went idle without pushing its number");

    // reset empties the output register and idles the front end
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the output or the front end");

endmodule

### rtl/gdf_front.sv
// Front end: accepts a request, takes its magnitude and converts it to BCD
// by shift-and-add-3, one bit per cycle. Depends on gdf_pkg.
module gdf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gdf_pkg::VALUE_BITS-1:0] s_tdata,
    input  logic [gdf_pkg::GRP_BITS-1:0]  group_size,
    output logic                          push,
    input  logic                          push_ready,
    output gdf_pkg::gdf_entry_t           push_entry
);
    import gdf_pkg::*;

    front_state_t            st_reg, st_next;
    logic [VALUE_BITS-1:0]   mag_reg;
    logic [BCD_BITS-1:0]     bcd_reg;
    logic [BCD_BITS-1:0]     bcd_adj;
    logic                    neg_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [GRP_BITS-1:0]     grp_reg;
    logic [GRP_BITS-1:0]     grp_inc;
    logic [DIGIT_COUNT-1:0]  mask_reg;
    logic                    accept;
    logic                    in_neg;

    assign in_neg  = s_tdata[VALUE_BITS-1];
    assign accept  = s_tvalid && s_tready;
    assign grp_inc = grp_reg + 1'b1;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (bcd_reg[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
                bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_reg[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
            end else begin
                bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_reg[i*DIGIT_BITS +: DIGIT_BITS];
            end
        end
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE:  if (s_tvalid) st_next = F_CONV;
            F_CONV:  if (cnt_reg == CNT_BITS'(VALUE_BITS - 1)) st_next = F_PUSH;
            F_PUSH:  if (push_ready) st_next = F_IDLE;
            default: st_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        push     = 1'b0;
        case (st_reg)
            F_IDLE:  s_tready = 1'b1;
            F_PUSH:  push = push_ready;
            default: begin
                s_tready = 1'b0;
                push     = 1'b0;
            end
        endcase
    end

    assign push_entry.bcd       = bcd_reg;
    assign push_entry.negative  = neg_reg;
    assign push_entry.sep_after = mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= F_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            // two's complement negate; the most negative value maps to 2^(N-1)
            mag_reg  <= in_neg ? (~s_tdata + 1'b1) : s_tdata;
            neg_reg  <= in_neg;
            bcd_reg  <= '0;
            cnt_reg  <= '0;
            grp_reg  <= '0;
            mask_reg <= '0;
        end else if (st_reg == F_CONV) begin
            bcd_reg <= {bcd_adj[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
            mag_reg <= {mag_reg[VALUE_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
            // grouping pattern in the first cycles: grp_reg tracks cnt_reg mod group_size
            if (cnt_reg < CNT_BITS'(DIGIT_COUNT)) begin
                mask_reg[cnt_reg[IDX_BITS-1:0]] <= (cnt_reg != '0) && (group_size != '0)
                                                   && (grp_reg == '0);
                grp_reg <= (grp_inc == group_size) ? '0 : grp_inc;
            end
        end
    end

endmodule

### rtl/gdf_queue.sv
// Two-entry queue of converted numbers between front end and emitter.
// Depends on gdf_pkg.
module gdf_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  gdf_pkg::gdf_entry_t push_entry,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output gdf_pkg::gdf_entry_t pop_entry
);
    import gdf_pkg::*;

    gdf_entry_t           mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;

    assign push_ready = (count_reg != QCNT_BITS'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/gdf_back.sv
// Emitter: skips leading zero digits, then sends sign, digits and separators
// via an output register, one per cycle unless stalled. Depends on gdf_pkg.
module gdf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    input  gdf_pkg::gdf_entry_t           pop_entry,
    output logic                          pop,
    input  logic [gdf_pkg::SEP_BITS-1:0]  separator,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gdf_pkg::CHAR_BITS-1:0] m_tdata,
    output logic                          m_tlast
);
    import gdf_pkg::*;

    back_state_t            st_reg, st_next;
    logic [BCD_BITS-1:0]    bcd_reg;
    logic                   neg_reg;
    logic [DIGIT_COUNT-1:0] sep_reg;
    logic [IDX_BITS-1:0]    idx_reg;
    logic [DIGIT_BITS-1:0]  digit;
    logic                   out_free;
    logic                   emit;
    logic [CHAR_BITS-1:0]   emit_char;
    logic                   emit_last;
    logic                   out_valid_reg;
    logic [CHAR_BITS-1:0]   out_char_reg;
    logic                   out_last_reg;

    assign digit    = bcd_reg[idx_reg*DIGIT_BITS +: DIGIT_BITS];
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE: if (pop_valid) st_next = B_SKIP;
            B_SKIP: begin
                if (idx_reg == '0 || digit != '0) begin
                    st_next = neg_reg ? B_SIGN : B_DIGIT;
                end
            end
            B_SIGN: if (out_free) st_next = B_DIGIT;
            B_DIGIT: begin
                if (out_free) begin
                    if (idx_reg == '0) begin
                        st_next = B_IDLE;
                    end else if (sep_reg[idx_reg]) begin
                        st_next = B_SEP;
                    end
                end
            end
            B_SEP:   if (out_free) st_next = B_DIGIT;
            default: st_next = B_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        emit      = 1'b0;
        emit_char = CHAR_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, digit};
        emit_last = 1'b0;
        case (st_reg)
            B_IDLE: pop = pop_valid;
            B_SIGN: begin
                emit      = out_free;
                emit_char = CHAR_MINUS;
            end
            B_DIGIT: begin
                emit      = out_free;
                emit_last = (idx_reg == '0);
            end
            B_SEP: begin
                emit      = out_free;
                emit_char = separator;
            end
            default: begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
        end
        if (pop) begin
            bcd_reg <= pop_entry.bcd;
            neg_reg <= pop_entry.negative;
            sep_reg <= pop_entry.sep_after;
            idx_reg <= IDX_BITS'(DIGIT_COUNT - 1);
        end else if (st_reg == B_SKIP) begin
            if (idx_reg != '0 && digit == '0) idx_reg <= idx_reg - 1'b1;
        end else if (emit && st_reg == B_DIGIT) begin
            if (idx_reg != '0 && !sep_reg[idx_reg]) idx_reg <= idx_reg - 1'b1;
        end else if (emit && st_reg == B_SEP) begin
            idx_reg <= idx_reg - 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule
